FILE: rtl/core/generational_handle_table_macros.svh
// Assertion macros shared by the handle table RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ght_pkg.sv
// Shared types and constants of the generational handle table.
package ght_pkg;

   localparam int SLOTS = 64;
   localparam int AGE_BITS = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AGE_CMP_W = (AGE_BITS > 8) ? AGE_BITS : 8;

   localparam logic [6:0] NONE = 7'h7F;
   localparam logic [6:0] SLOT_LIMIT = 7'(SLOTS);
   localparam logic [AGE_CMP_W-1:0] AGE_MASK = AGE_CMP_W'({AGE_BITS{1'b1}});

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_DESTROY = 3'd1;
   localparam logic [2:0] OP_QUERY = 3'd2;
   localparam logic [2:0] OP_SET_OWNER = 3'd3;
   localparam logic [2:0] OP_GET_OWNER = 3'd4;
   localparam logic [2:0] OP_FLUSH = 3'd5;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_STALE = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_WRONG_TYPE = 3'd3;
   localparam logic [2:0] ST_NONE_PENDING = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] handle_type;
      logic [5:0] slot_index;
      logic [7:0] handle_age;
      logic [31:0] owner_value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] out_slot;
      logic [7:0] out_age;
      logic is_valid;
      logic [31:0] owner_out;
      logic [5:0] dense_position;
      logic moved;
      logic [5:0] moved_from;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic rd_req;
      logic rd_scan;
      logic ex;
      logic fa;
      logic fb;
      logic emit;
      logic scan_inc;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic pend_none;
      logic pend_cur;
      logic res_last;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/core/ght_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ght_ctrl.sv
// Controller state machine that sequences single-slot operations and flush walks.
module ght_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ght_pkg::sts_type sts,
   output ght_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RD    = 8'b0000_0010,
      S_EX    = 8'b0000_0100,
      S_EMIT  = 8'b0000_1000,
      S_FSCAN = 8'b0001_0000,
      S_FA    = 8'b0010_0000,
      S_FB    = 8'b0100_0000,
      S_FEMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_req = 1'b1;
            if (sts.opcode == ght_pkg::OP_FLUSH) begin
               state_in = sts.pend_none ? S_EX : S_FSCAN;
            end else if (sts.opcode > ght_pkg::OP_FLUSH) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EX;
            end
         end
         S_EX: begin
            cmd.ex = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FSCAN: begin
            if (sts.pend_cur) begin
               cmd.rd_scan = 1'b1;
               state_in = S_FA;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_FA: begin
            cmd.fa = 1'b1;
            state_in = S_FB;
         end
         S_FB: begin
            cmd.fb = 1'b1;
            state_in = S_FEMIT;
         end
         S_FEMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.res_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_inc = 1'b1;
                  state_in = S_FSCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`include "generational_handle_table_macros.svh"

   `GHT_ASSERT_NEXT(a_fb_after_fa, clock, reset, cmd.fa, cmd.fb, "Flush second step did not follow the first.")
   `GHT_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff), "State is not one-hot.")
   `GHT_ASSERT_NEXT(a_capture_read, clock, reset, cmd.capture, state_ff == S_RD, "Read did not follow capture.")

endmodule

FILE: rtl/core/ght_dpath.sv
// Datapath with the slot stores, free list, dense array and result registers.
module ght_dpath (
   input  logic clock,
   input  logic reset,
   input  ght_pkg::req_type req_data,
   input  logic csr_wr_en,
   input  logic [6:0] csr_wr_data,
   input  ght_pkg::cmd_type cmd,
   output ght_pkg::sts_type sts,
   output logic rsp_valid,
   output ght_pkg::rsp_type rsp_data,
   input  logic rsp_stall
);

   localparam int SW = ght_pkg::SLOT_W;
   localparam int AB = ght_pkg::AGE_BITS;

   ght_pkg::req_type req_ff, req_in;
   logic [6:0] type_tag_ff;
   logic [6:0] free_head_ff, free_head_in;
   logic [6:0] free_tail_ff, free_tail_in;
   logic [6:0] used_ff, used_in;
   logic [ght_pkg::SLOTS-1:0] pend_ff, pend_in;
   logic [ght_pkg::SLOTS-1:0] age_vld_ff, dense_vld_ff, link_vld_ff;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] a_addr_ff, a_addr;
   logic [SW-1:0] b_addr;
   logic [6:0] d_ff, d_in;
   logic [5:0] ms_ff, ms_in;
   logic mv_ff, mv_in;
   logic [5:0] mfrom_ff, mfrom_in;
   logic [AB-1:0] fage_ff, fage_in;
   ght_pkg::rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   ght_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic age_we, dense_we, link_we, dslot_we, owner_we;
   logic [SW-1:0] age_wa, dense_wa, link_wa, dslot_wa, owner_wa;
   logic [AB-1:0] age_wd, age_ram_rd, age_rd;
   logic [6:0] dense_wd, dense_ram_rd, dense_rd;
   logic [6:0] link_wd, link_ram_rd, link_rd, link_rst;
   logic [5:0] dslot_wd, dslot_rd;
   logic [31:0] owner_wd, owner_rd;

   logic out_free;
   logic tag_ok, in_range, age_ok, full;
   logic [6:0] lastd;
   logic [AB-1:0] age_next;
   logic [ght_pkg::SLOTS-1:0] pend_after;

   ght_ram #(.WIDTH(AB), .DEPTH(ght_pkg::SLOTS)) u_age_ram (
      .clock(clock), .wr_en(age_we), .wr_addr(age_wa), .wr_data(age_wd),
      .rd_addr(a_addr), .rd_data(age_ram_rd));

   ght_ram #(.WIDTH(7), .DEPTH(ght_pkg::SLOTS)) u_dense_ram (
      .clock(clock), .wr_en(dense_we), .wr_addr(dense_wa), .wr_data(dense_wd),
      .rd_addr(a_addr), .rd_data(dense_ram_rd));

   ght_ram #(.WIDTH(7), .DEPTH(ght_pkg::SLOTS)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(a_addr), .rd_data(link_ram_rd));

   ght_ram #(.WIDTH(6), .DEPTH(ght_pkg::SLOTS)) u_dslot_ram (
      .clock(clock), .wr_en(dslot_we), .wr_addr(dslot_wa), .wr_data(dslot_wd),
      .rd_addr(b_addr), .rd_data(dslot_rd));

   ght_ram #(.WIDTH(32), .DEPTH(ght_pkg::SLOTS)) u_owner_ram (
      .clock(clock), .wr_en(owner_we), .wr_addr(owner_wa), .wr_data(owner_wd),
      .rd_addr(a_addr), .rd_data(owner_rd));

   // Age, dense and link entries that were never written read as their reset values.
   assign link_rst = ((7'(a_addr_ff) + 7'd1) < ght_pkg::SLOT_LIMIT) ?
                     (7'(a_addr_ff) + 7'd1) : ght_pkg::NONE;
   assign age_rd = age_vld_ff[a_addr_ff] ? age_ram_rd : '0;
   assign dense_rd = dense_vld_ff[a_addr_ff] ? dense_ram_rd : ght_pkg::NONE;
   assign link_rd = link_vld_ff[a_addr_ff] ? link_ram_rd : link_rst;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign lastd = used_ff - 7'd1;
   assign b_addr = lastd[SW-1:0];

   always_comb begin
      a_addr = a_addr_ff;
      if (cmd.rd_req) begin
         a_addr = (req_ff.opcode == ght_pkg::OP_CREATE) ? free_head_ff[SW-1:0]
                                                          : req_ff.slot_index[SW-1:0];
      end else if (cmd.rd_scan) begin
         a_addr = scan_ff;
      end
   end

   assign tag_ok = (req_ff.handle_type == type_tag_ff);
   assign in_range = (7'(req_ff.slot_index) < ght_pkg::SLOT_LIMIT);
   assign age_ok = ((ght_pkg::AGE_CMP_W'(req_ff.handle_age) & ght_pkg::AGE_MASK) ==
                    ght_pkg::AGE_CMP_W'(age_rd));
   assign full = (free_head_ff >= ght_pkg::SLOT_LIMIT) || (used_ff >= ght_pkg::SLOT_LIMIT) ||
                 (link_rd >= ght_pkg::SLOT_LIMIT);
   assign age_next = age_rd + AB'(1);
   assign pend_after = pend_ff & ~(ght_pkg::SLOTS'(1) << scan_ff);

   always_comb begin
      req_in = cmd.capture ? req_data : req_ff;
      free_head_in = free_head_ff;
      free_tail_in = free_tail_ff;
      used_in = used_ff;
      pend_in = pend_ff;
      scan_in = scan_ff;
      d_in = d_ff;
      ms_in = ms_ff;
      mv_in = mv_ff;
      mfrom_in = mfrom_ff;
      fage_in = fage_ff;
      res_in = res_ff;
      age_we = 1'b0;
      age_wa = req_ff.slot_index[SW-1:0];
      age_wd = age_next;
      dense_we = 1'b0;
      dense_wa = scan_ff;
      dense_wd = ght_pkg::NONE;
      link_we = 1'b0;
      link_wa = scan_ff;
      link_wd = ght_pkg::NONE;
      dslot_we = 1'b0;
      dslot_wa = used_ff[SW-1:0];
      dslot_wd = 6'(free_head_ff);
      owner_we = 1'b0;
      owner_wa = req_ff.slot_index[SW-1:0];
      owner_wd = req_ff.owner_value;

      if (cmd.capture) begin
         scan_in = '0;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + SW'(1);
      end

      if (cmd.ex) begin
         res_in = '0;
         res_in.last = 1'b1;
         if (req_ff.opcode == ght_pkg::OP_CREATE) begin
            if (full) begin
               res_in.status = ght_pkg::ST_FULL;
            end else begin
               dense_we = 1'b1;
               dense_wa = free_head_ff[SW-1:0];
               dense_wd = used_ff;
               dslot_we = 1'b1;
               link_we = 1'b1;
               link_wa = free_head_ff[SW-1:0];
               owner_we = 1'b1;
               owner_wa = free_head_ff[SW-1:0];
               owner_wd = '0;
               used_in = used_ff + 7'd1;
               free_head_in = link_rd;
               res_in.status = ght_pkg::ST_OK;
               res_in.out_slot = 6'(free_head_ff);
               res_in.out_age = 8'(age_rd);
               res_in.is_valid = 1'b1;
               res_in.dense_position = 6'(used_ff);
            end
         end else if (req_ff.opcode == ght_pkg::OP_FLUSH) begin
            res_in.status = ght_pkg::ST_NONE_PENDING;
         end else if (!tag_ok) begin
            res_in.status = ght_pkg::ST_WRONG_TYPE;
            res_in.out_slot = req_ff.slot_index;
         end else if (!in_range) begin
            res_in.status = ght_pkg::ST_STALE;
            res_in.out_slot = req_ff.slot_index;
         end else begin
            res_in.out_slot = req_ff.slot_index;
            res_in.out_age = 8'(age_rd);
            res_in.is_valid = age_ok;
            res_in.status = age_ok ? ght_pkg::ST_OK : ght_pkg::ST_STALE;
            priority if (req_ff.opcode == ght_pkg::OP_DESTROY) begin
               res_in.dense_position = (dense_rd < ght_pkg::SLOT_LIMIT) ? 6'(dense_rd) : '0;
               if (!age_ok || dense_rd >= ght_pkg::SLOT_LIMIT) begin
                  res_in.status = ght_pkg::ST_STALE;
               end else if (!pend_ff[req_ff.slot_index[SW-1:0]]) begin
                  pend_in[req_ff.slot_index[SW-1:0]] = 1'b1;
                  age_we = 1'b1;
                  res_in.out_age = 8'(age_next);
               end
            end else if (req_ff.opcode == ght_pkg::OP_QUERY) begin
               res_in.status = ght_pkg::ST_OK;
            end else if (req_ff.opcode == ght_pkg::OP_SET_OWNER) begin
               owner_we = age_ok;
            end else begin
               res_in.owner_out = age_ok ? owner_rd : '0;
            end
         end
      end

      if (cmd.fa) begin
         d_in = dense_rd;
         ms_in = dslot_rd;
         fage_in = age_rd;
         mfrom_in = 6'(lastd);
         mv_in = (used_ff != 7'd0) && (dense_rd < lastd);
         dense_we = 1'b1;
         if (free_tail_ff < ght_pkg::SLOT_LIMIT) begin
            link_we = 1'b1;
            link_wa = free_tail_ff[SW-1:0];
            link_wd = 7'(scan_ff);
         end else begin
            free_head_in = 7'(scan_ff);
         end
         if ((used_ff != 7'd0) && (dense_rd < lastd)) begin
            dslot_we = 1'b1;
            dslot_wa = dense_rd[SW-1:0];
            dslot_wd = dslot_rd;
         end
      end

      if (cmd.fb) begin
         if (mv_ff && (7'(ms_ff) < ght_pkg::SLOT_LIMIT)) begin
            dense_we = 1'b1;
            dense_wa = ms_ff[SW-1:0];
            dense_wd = d_ff;
         end
         link_we = 1'b1;
         free_tail_in = 7'(scan_ff);
         pend_in = pend_after;
         if (used_ff != 7'd0) begin
            used_in = used_ff - 7'd1;
         end
         res_in = '0;
         res_in.status = ght_pkg::ST_OK;
         res_in.out_slot = 6'(scan_ff);
         res_in.out_age = 8'(fage_ff);
         res_in.dense_position = 6'(d_ff);
         res_in.moved = mv_ff;
         res_in.moved_from = mv_ff ? mfrom_ff : '0;
         res_in.last = (pend_after == '0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_tag_ff <= 7'd1;
         free_head_ff <= 7'd0;
         free_tail_ff <= 7'(ght_pkg::SLOTS - 1);
         used_ff <= 7'd0;
         pend_ff <= '0;
         age_vld_ff <= '0;
         dense_vld_ff <= '0;
         link_vld_ff <= '0;
         scan_ff <= '0;
         a_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            type_tag_ff <= csr_wr_data;
         end
         free_head_ff <= free_head_in;
         free_tail_ff <= free_tail_in;
         used_ff <= used_in;
         pend_ff <= pend_in;
         if (age_we) begin
            age_vld_ff[age_wa] <= 1'b1;
         end
         if (dense_we) begin
            dense_vld_ff[dense_wa] <= 1'b1;
         end
         if (link_we) begin
            link_vld_ff[link_wa] <= 1'b1;
         end
         scan_ff <= scan_in;
         a_addr_ff <= a_addr;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      d_ff <= d_in;
      ms_ff <= ms_in;
      mv_ff <= mv_in;
      mfrom_ff <= mfrom_in;
      fage_ff <= fage_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.opcode = req_ff.opcode;
   assign sts.pend_none = (pend_ff == '0);
   assign sts.pend_cur = pend_ff[scan_ff];
   assign sts.res_last = res_ff.last;
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`include "generational_handle_table_macros.svh"

   `GHT_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_ff < ght_pkg::SLOT_LIMIT, "Use count reached the slot count.")
   `GHT_ASSERT_NOW(a_free_nonempty, clock, reset, 1'b1, free_head_ff < ght_pkg::SLOT_LIMIT, "Free list ran empty.")
   `GHT_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, out_free, "Result loaded over an untaken one.")

endmodule

FILE: rtl/core/generational_handle_table.sv
// Generational handle table: top level joining the controller and the datapath.
// Create, destroy, query, set owner and get owner each go through read, execute and emit.
// A new request is taken only after the previous one is done; a stall holds the result.
// Flush scans slots up to the last pending one, releasing each pending slot in the FA and
// FB steps and emitting its result; with nothing pending it emits one none-pending result.
// Synchronous active-high reset empties the table and sets the type tag to 1.
module generational_handle_table (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ght_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ght_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   ght_pkg::cmd_type cmd;
   ght_pkg::sts_type sts;

   ght_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts(sts),
      .cmd(cmd)
   );

   ght_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd(cmd),
      .sts(sts),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_stall(rsp_stall)
   );

endmodule

FILE: bench/ght_checker.sv
// Checker for the handle table: predicts every result and compares it with the block.
`timescale 1ns / 100ps
module ght_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  ght_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  ght_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [6:0] csr_wr_data,
   output int fail_count,
   output int pending_count,
   output int result_count
);

   logic [6:0] tag;
   logic [7:0] slot_age [ght_pkg::SLOTS];
   logic [6:0] slot_dense [ght_pkg::SLOTS];
   logic [6:0] slot_link [ght_pkg::SLOTS];
   logic [5:0] dense_slot [ght_pkg::SLOTS];
   logic [31:0] slot_owner [ght_pkg::SLOTS];
   bit slot_pending [ght_pkg::SLOTS];
   logic [6:0] free_head, free_tail, used;
   ght_pkg::rsp_type due_rsp [$];
   int errors = 0;
   int seen = 0;

   assign fail_count = errors;
   assign pending_count = due_rsp.size();
   assign result_count = seen;

   function automatic ght_pkg::rsp_type make_rsp(logic [2:0] st, logic [5:0] slot,
                                                 logic [7:0] age, logic valid,
                                                 logic [31:0] own, logic [5:0] dpos,
                                                 logic mv, logic [5:0] mfrom, logic fin);
      ght_pkg::rsp_type r;
      r.status = st;
      r.out_slot = slot;
      r.out_age = age;
      r.is_valid = valid;
      r.owner_out = own;
      r.dense_position = dpos;
      r.moved = mv;
      r.moved_from = mfrom;
      r.last = fin;
      return r;
   endfunction

   task automatic predict_table(input ght_pkg::req_type q);
      logic [6:0] s, d, lastd, ms;
      logic [7:0] age;
      logic valid, mv;
      logic [5:0] dpos, mfrom;
      int n;
      s = {1'b0, q.slot_index};
      n = 0;
      if (q.opcode == ght_pkg::OP_CREATE) begin
         s = free_head;
         if (s >= ght_pkg::SLOT_LIMIT || used >= ght_pkg::SLOT_LIMIT ||
             slot_link[s[5:0]] >= ght_pkg::SLOT_LIMIT) begin
            due_rsp.push_back(make_rsp(ght_pkg::ST_FULL, 6'd0, 8'd0, 1'b0, 32'd0, 6'd0,
                                       1'b0, 6'd0, 1'b1));
         end else begin
            d = used;
            slot_dense[s] = d;
            dense_slot[d] = s[5:0];
            used = used + 7'd1;
            free_head = slot_link[s];
            slot_link[s] = ght_pkg::NONE;
            slot_owner[s] = 32'd0;
            due_rsp.push_back(make_rsp(ght_pkg::ST_OK, s[5:0], slot_age[s], 1'b1, 32'd0,
                                       d[5:0], 1'b0, 6'd0, 1'b1));
         end
      end else if (q.opcode == ght_pkg::OP_FLUSH) begin
         for (int i = 0; i < ght_pkg::SLOTS; i++) begin
            if (slot_pending[i]) begin
               slot_pending[i] = 0;
               d = slot_dense[i];
               mv = 1'b0;
               mfrom = 6'd0;
               slot_dense[i] = ght_pkg::NONE;
               if (free_tail < ght_pkg::SLOT_LIMIT) slot_link[free_tail] = 7'(i);
               else free_head = 7'(i);
               free_tail = 7'(i);
               slot_link[i] = ght_pkg::NONE;
               if (used > 7'd0) begin
                  lastd = used - 7'd1;
                  if (d < lastd) begin
                     ms = {1'b0, dense_slot[lastd]};
                     dense_slot[d] = ms[5:0];
                     slot_dense[ms] = d;
                     mv = 1'b1;
                     mfrom = lastd[5:0];
                  end
                  used = used - 7'd1;
               end
               due_rsp.push_back(make_rsp(ght_pkg::ST_OK, 6'(i), slot_age[i], 1'b0, 32'd0,
                                          d[5:0], mv, mfrom, 1'b0));
               n++;
            end
         end
         if (n == 0) begin
            due_rsp.push_back(make_rsp(ght_pkg::ST_NONE_PENDING, 6'd0, 8'd0, 1'b0, 32'd0,
                                       6'd0, 1'b0, 6'd0, 1'b1));
         end else begin
            due_rsp[$].last = 1'b1;
         end
      end else if (q.opcode <= ght_pkg::OP_GET_OWNER) begin
         if (q.handle_type != tag) begin
            due_rsp.push_back(make_rsp(ght_pkg::ST_WRONG_TYPE, s[5:0], 8'd0, 1'b0, 32'd0,
                                       6'd0, 1'b0, 6'd0, 1'b1));
         end else begin
            age = slot_age[s];
            valid = (q.handle_age == age);
            dpos = (slot_dense[s] < ght_pkg::SLOT_LIMIT) ? slot_dense[s][5:0] : 6'd0;
            case (q.opcode)
               ght_pkg::OP_DESTROY: begin
                  if (!valid || slot_dense[s] >= ght_pkg::SLOT_LIMIT) begin
                     due_rsp.push_back(make_rsp(ght_pkg::ST_STALE, s[5:0], age, valid, 32'd0,
                                                dpos, 1'b0, 6'd0, 1'b1));
                  end else begin
                     if (!slot_pending[s]) begin
                        slot_pending[s] = 1;
                        slot_age[s] = age + 8'd1;
                     end
                     due_rsp.push_back(make_rsp(ght_pkg::ST_OK, s[5:0], slot_age[s], 1'b1,
                                                32'd0, dpos, 1'b0, 6'd0, 1'b1));
                  end
               end
               ght_pkg::OP_QUERY: begin
                  due_rsp.push_back(make_rsp(ght_pkg::ST_OK, s[5:0], age, valid, 32'd0, 6'd0,
                                             1'b0, 6'd0, 1'b1));
               end
               ght_pkg::OP_SET_OWNER: begin
                  if (valid) slot_owner[s] = q.owner_value;
                  due_rsp.push_back(make_rsp(valid ? ght_pkg::ST_OK : ght_pkg::ST_STALE,
                                             s[5:0], age, valid, 32'd0, 6'd0, 1'b0, 6'd0,
                                             1'b1));
               end
               default: begin
                  due_rsp.push_back(make_rsp(valid ? ght_pkg::ST_OK : ght_pkg::ST_STALE,
                                             s[5:0], age, valid,
                                             valid ? slot_owner[s] : 32'd0, 6'd0, 1'b0,
                                             6'd0, 1'b1));
               end
            endcase
         end
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      ght_pkg::rsp_type w;
      if (reset) begin
         tag = 7'd1;
         for (int i = 0; i < ght_pkg::SLOTS; i++) begin
            slot_age[i] = 8'd0;
            slot_dense[i] = ght_pkg::NONE;
            slot_link[i] = (i + 1 < ght_pkg::SLOTS) ? 7'(i + 1) : ght_pkg::NONE;
            dense_slot[i] = 6'd0;
            slot_owner[i] = 32'd0;
            slot_pending[i] = 0;
         end
         free_head = 7'd0;
         free_tail = 7'(ght_pkg::SLOTS - 1);
         used = 7'd0;
         due_rsp.delete();
      end else begin
         if (csr_wr_en) tag = csr_wr_data;
         if (req_valid && !req_stall) predict_table(req_data);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (due_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_data);
            end else begin
               w = due_rsp.pop_front();
               check_field("status", 32'(w.status), 32'(rsp_data.status));
               check_field("out_slot", 32'(w.out_slot), 32'(rsp_data.out_slot));
               check_field("out_age", 32'(w.out_age), 32'(rsp_data.out_age));
               check_field("is_valid", 32'(w.is_valid), 32'(rsp_data.is_valid));
               check_field("owner_out", w.owner_out, rsp_data.owner_out);
               check_field("dense_position", 32'(w.dense_position),
                           32'(rsp_data.dense_position));
               check_field("moved", 32'(w.moved), 32'(rsp_data.moved));
               check_field("moved_from", 32'(w.moved_from), 32'(rsp_data.moved_from));
               check_field("last", 32'(w.last), 32'(rsp_data.last));
            end
         end
      end
   end
endmodule

FILE: bench/tb.sv
// Testbench top for the handle table: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb;

   localparam int LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   ght_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   ght_pkg::rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [6:0] csr_wr_data = 7'd0;
   int fail_count, pending_count, result_count;
   logic [6:0] cur_tag = 7'd1;
   bit quiet = 0;
   bit hold_go = 0;
   int sent = 0;

   always #10 clock = ~clock;

   generational_handle_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   ght_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
   );

   task automatic send_request(input logic [2:0] op, input logic [6:0] ht, input logic [5:0] slot,
                               input logic [7:0] age, input logic [31:0] own);
      ght_pkg::req_type r;
      r.opcode = op;
      r.handle_type = ht;
      r.slot_index = slot;
      r.handle_age = age;
      r.owner_value = own;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain_and_write(input logic [6:0] value);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      cur_tag = value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic random_requests(input int count);
      int n;
      int w;
      logic [2:0] op;
      logic [6:0] ht;
      logic [5:0] slot;
      logic [7:0] age;
      n = 0;
      while (n < count) begin
         w = $urandom_range(0, 99);
         if (w < 25) op = ght_pkg::OP_CREATE;
         else if (w < 45) op = ght_pkg::OP_DESTROY;
         else if (w < 57) op = ght_pkg::OP_QUERY;
         else if (w < 69) op = ght_pkg::OP_SET_OWNER;
         else if (w < 81) op = ght_pkg::OP_GET_OWNER;
         else if (w < 93) op = ght_pkg::OP_FLUSH;
         else op = 3'($urandom_range(6, 7));
         ht = ($urandom_range(0, 99) < 85) ? cur_tag : 7'($urandom_range(0, 127));
         slot = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
         age = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
         // Slots 0 to 3 are created first, so an age-0 owner read never hits an unwritten entry.
         if (op == ght_pkg::OP_GET_OWNER && age == 8'd0) slot = 6'($urandom_range(0, 3));
         send_request(op, ht, slot, age, $urandom);
         if (op <= ght_pkg::OP_FLUSH) n++;
      end
   endtask

   initial begin
      forever begin
         if (hold_go) begin
            hold_go = 0;
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("generational_handle_table regression: fail");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(ght_pkg::OP_FLUSH, 7'd1, 6'd0, 8'd0, 32'd0);
      repeat (4) send_request(ght_pkg::OP_CREATE, 7'h55, 6'h2A, 8'hAA, 32'h5555_5555);
      send_request(ght_pkg::OP_GET_OWNER, 7'd1, 6'd0, 8'd0, 32'd0);
      send_request(ght_pkg::OP_SET_OWNER, 7'd1, 6'd0, 8'd0, 32'hFFFF_FFFF);
      send_request(ght_pkg::OP_GET_OWNER, 7'd1, 6'd0, 8'd0, 32'd0);
      send_request(ght_pkg::OP_SET_OWNER, 7'd1, 6'd1, 8'hFF, 32'h1234_5678);
      send_request(ght_pkg::OP_QUERY, 7'd1, 6'd63, 8'd0, 32'd0);
      send_request(ght_pkg::OP_QUERY, 7'd1, 6'd2, 8'hFF, 32'd0);
      send_request(ght_pkg::OP_DESTROY, 7'd1, 6'd1, 8'd0, 32'd0);
      send_request(ght_pkg::OP_DESTROY, 7'd1, 6'd1, 8'd1, 32'd0);
      send_request(ght_pkg::OP_DESTROY, 7'd1, 6'd1, 8'd0, 32'd0);
      send_request(ght_pkg::OP_DESTROY, 7'd1, 6'd40, 8'd0, 32'd0);
      send_request(ght_pkg::OP_DESTROY, 7'd127, 6'd2, 8'd0, 32'd0);
      send_request(ght_pkg::OP_QUERY, 7'd0, 6'd2, 8'd0, 32'd0);
      send_request(ght_pkg::OP_GET_OWNER, 7'd1, 6'd1, 8'd1, 32'd0);
      send_request(ght_pkg::OP_DESTROY, 7'd1, 6'd0, 8'd0, 32'd0);
      send_request(ght_pkg::OP_FLUSH, 7'd1, 6'd0, 8'd0, 32'd0);
      send_request(3'd6, 7'd1, 6'd0, 8'd0, 32'd0);
      send_request(3'd7, 7'h7F, 6'h3F, 8'hFF, 32'hFFFF_FFFF);
      send_request(ght_pkg::OP_CREATE, 7'd0, 6'd0, 8'd0, 32'd0);
      drain_and_write(7'd127);
      hold_go = 1;
      random_requests(30);
      repeat (66) send_request(ght_pkg::OP_CREATE, 7'($urandom_range(0, 127)),
                               6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), $urandom);
      random_requests(15);
      drain_and_write(7'($urandom_range(2, 126)));
      random_requests(25);
      drain_and_write(7'd1);
      quiet = 1;
      random_requests(20);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Run covered %0d requests and %0d results over type tags 1, 127 and a random one,",
               sent, result_count);
      $display("with a full table, flush compaction and a long result hold-off.");
      if (fail_count == 0) begin
         $display("generational_handle_table regression: pass");
      end else begin
         $display("generational_handle_table regression: fail");
      end
      $finish;
   end
endmodule
